// ----- rtl/core/tfu_pkg.sv -----
// ----------------------------------------------------------------------------
// tfu_pkg: shared types and constants of the fixed-point transcendental unit
// Q16.16 word format, function codes, sequencer states and divider handshake.
// ----------------------------------------------------------------------------
package tfu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIM_BITS  = 31;
  localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t ONE       = word_t'(32'sd65536);
  localparam word_t TWO       = word_t'(32'sd131072);
  localparam word_t WMAX      = word_t'(32'sh7FFFFFFF);
  localparam word_t WMIN      = word_t'(32'sh80000000);
  localparam word_t E_FIX     = word_t'(32'sd178145);
  localparam word_t LN2_FIX   = word_t'(32'sd45426);
  localparam word_t EXP_STOP  = word_t'(32'sd20);
  localparam word_t SQRT_SMALL = word_t'(32'sd6);
  localparam int    EXP_TERMS = 14;
  localparam int    SQRT_DEF_ITER = 16;
  localparam int    LOG_MAX_HALF = 32;
  localparam logic [LIM_BITS-1:0] EXP_LIM_RESET = 31'd681391;

  // Log polynomial coefficients, Q16.16.
  localparam word_t LG0 = word_t'(32'sd43690);
  localparam word_t LG1 = word_t'(32'sd26214);
  localparam word_t LG2 = word_t'(32'sd18724);
  localparam word_t LG3 = word_t'(32'sd14563);
  localparam word_t LG4 = word_t'(32'sd11916);
  localparam word_t LG5 = word_t'(32'sd10036);
  localparam word_t LG6 = word_t'(32'sd9698);

  typedef enum logic [1:0] {
    FN_SQRT = 2'd0,
    FN_EXP  = 2'd1,
    FN_LOG  = 2'd2,
    FN_TANH = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_SQ_INV,
    ST_SQ_PREP,
    ST_SQ_CNT,
    ST_SQ_ITER,
    ST_SQ_FIN,
    ST_EX_DIV,
    ST_EX_MUL,
    ST_EX_FIN,
    ST_LG_SHIFT,
    ST_LG_DIV,
    ST_LG_POLY,
    ST_TH_X2,
    ST_TH_LOOP,
    ST_TH_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
  } div_rsp_t;

  // Fixed-point product: bits [47:16] of the full signed product.
  function automatic word_t fmul(input word_t a, input word_t b);
    logic signed [2*WORD_BITS-1:0] p;
    p = a * b;
    return p[FRAC_BITS +: WORD_BITS];
  endfunction

  function automatic word_t fx(input logic [5:0] n);
    return word_t'({26'd0, n}) <<< FRAC_BITS;
  endfunction

endpackage

// ----- rtl/core/tfu_div.sv -----
// ----------------------------------------------------------------------------
// tfu_div: iterative fixed-point divider
// Computes (a << 16) / b truncated toward zero, one quotient bit per cycle; b = 0 gives WMAX or WMIN by the sign of a.
// ----------------------------------------------------------------------------
module tfu_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tfu_pkg::div_req_t req,
  output tfu_pkg::div_rsp_t rsp
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [tfu_pkg::DIV_CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [tfu_pkg::DIV_STEPS-1:0]       dvd_r, dvd_nxt;
  logic [tfu_pkg::WORD_BITS-1:0]       dvs_r, dvs_nxt;
  logic [tfu_pkg::WORD_BITS-1:0]       rem_r, rem_nxt;
  logic [tfu_pkg::WORD_BITS-1:0]       quo_r, quo_nxt;
  logic                                neg_r, neg_nxt;
  tfu_pkg::word_t                      res_r, res_nxt;
  logic [tfu_pkg::WORD_BITS:0]         rem_sh;
  logic [tfu_pkg::WORD_BITS-1:0]       mag_a, mag_b;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    mag_a    = req.dividend[tfu_pkg::WORD_BITS-1] ? 32'(-req.dividend) : 32'(req.dividend);
    mag_b    = req.divisor[tfu_pkg::WORD_BITS-1] ? 32'(-req.divisor) : 32'(req.divisor);
    rem_sh   = {rem_r, dvd_r[tfu_pkg::DIV_STEPS-1]};
    if (busy_r) begin
      quo_nxt = {quo_r[tfu_pkg::WORD_BITS-2:0], 1'b0};
      rem_nxt = rem_sh[tfu_pkg::WORD_BITS-1:0];
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt    = 32'(rem_sh - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? tfu_pkg::word_t'(-quo_nxt) : tfu_pkg::word_t'(quo_nxt);
      end
    end else if (req.start) begin
      if (req.divisor == '0) begin
        done_nxt = 1'b1;
        res_nxt  = req.dividend[tfu_pkg::WORD_BITS-1] ? tfu_pkg::WMIN : tfu_pkg::WMAX;
      end else begin
        busy_nxt = 1'b1;
        dvd_nxt  = {mag_a, {tfu_pkg::FRAC_BITS{1'b0}}};
        dvs_nxt  = mag_b;
        rem_nxt  = '0;
        quo_nxt  = '0;
        neg_nxt  = req.dividend[tfu_pkg::WORD_BITS-1] ^ req.divisor[tfu_pkg::WORD_BITS-1];
        cnt_nxt  = tfu_pkg::DIV_CNT_BITS'(tfu_pkg::DIV_STEPS - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = res_r;

endmodule

// ----- rtl/core/fixed_point_transcendental_unit.sv -----
// Every division runs on the shared divider; sqrt runs Newton steps, plus two
// reciprocals for small fractions; special operands skip the iterations.
// Throughput: one beat at a time; the divider loop sets the rate.
// Reset: rst_n (synchronous, active low) idles the sequencer, drops out_tvalid
// and loads exp_saturation_limit with 681391.
// ----------------------------------------------------------------------------
// fixed_point_transcendental_unit: Q16.16 sqrt, exp, log and tanh
// A small sequencer drives one iterative divider and one multiplier to run
// Newton square root, a Taylor exponential, a polynomial log and a
// continued-fraction tanh.
// ----------------------------------------------------------------------------
module fixed_point_transcendental_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result
  input  logic        cfg_wen,
  input  logic [30:0] cfg_wdata   // exp_saturation_limit
);

  tfu_pkg::state_t state_r, state_nxt;
  tfu_pkg::func_t  func_r, func_nxt;
  tfu_pkg::word_t  a_r, a_nxt;      // operand / working argument
  tfu_pkg::word_t  l_r, l_nxt;      // Newton estimate, exp sum
  tfu_pkg::word_t  t_r, t_nxt;      // exp term, tanh fraction, log partial
  tfu_pkg::word_t  u_r, u_nxt;      // scratch
  tfu_pkg::word_t  f_r, f_nxt;
  tfu_pkg::word_t  s_r, s_nxt;
  tfu_pkg::word_t  z_r, z_nxt;
  tfu_pkg::word_t  w_r, w_nxt;
  tfu_pkg::word_t  res_r, res_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [3:0]      step_r, step_nxt;
  logic            inv_r, inv_nxt;
  logic            div_pend_r, div_pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_data_r, out_data_nxt;
  logic [30:0]     lim_r;

  tfu_pkg::div_req_t div_req;
  tfu_pkg::div_rsp_t div_rsp;
  tfu_pkg::word_t    mul_a, mul_b, mul_p, sum_w, q;
  logic              div_use, div_ok;
  logic signed [32:0] a33, lim33;

  tfu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // The one multiplier: operands are picked by the sequencer state.
  assign mul_p = tfu_pkg::fmul(mul_a, mul_b);
  assign q     = div_rsp.quot;
  // A division result is used only in the cycle its done pulse arrives.
  assign div_ok = div_pend_r && div_rsp.done;

  assign a33   = {a_r[31], a_r};
  assign lim33 = {2'b00, lim_r};

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    a_nxt         = a_r;
    l_nxt         = l_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    f_nxt         = f_r;
    s_nxt         = s_r;
    z_nxt         = z_r;
    w_nxt         = w_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    inv_nxt       = inv_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_use       = 1'b0;
    div_req.dividend = a_r;
    div_req.divisor  = l_r;
    mul_a         = a_r;
    mul_b         = a_r;
    sum_w         = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tfu_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = tfu_pkg::func_t'(in_tuser);
          a_nxt     = tfu_pkg::word_t'(in_tdata);
          state_nxt = tfu_pkg::ST_START;
        end
      end
      tfu_pkg::ST_START: begin
        state_nxt = tfu_pkg::ST_DONE;
        case (func_r)
          tfu_pkg::FN_SQRT: begin
            inv_nxt = 1'b0;
            if (a_r < 0) begin
              res_nxt = -32'sd1;
            end else if (a_r == '0 || a_r == tfu_pkg::ONE) begin
              res_nxt = a_r;
            end else if (a_r < tfu_pkg::ONE && a_r > tfu_pkg::SQRT_SMALL) begin
              inv_nxt   = 1'b1;
              state_nxt = tfu_pkg::ST_SQ_INV;
            end else begin
              state_nxt = tfu_pkg::ST_SQ_PREP;
            end
          end
          tfu_pkg::FN_EXP: begin
            if (a_r == '0) begin
              res_nxt = tfu_pkg::ONE;
            end else if (a_r == tfu_pkg::ONE) begin
              res_nxt = tfu_pkg::E_FIX;
            end else if (a33 >= lim33) begin
              res_nxt = tfu_pkg::WMAX;
            end else if (a33 <= -lim33) begin
              res_nxt = '0;
            end else begin
              // Work on the magnitude; a negative operand takes a reciprocal.
              inv_nxt   = a_r[31];
              a_nxt     = a_r[31] ? -a_r : a_r;
              t_nxt     = a_r[31] ? -a_r : a_r;
              l_nxt     = (a_r[31] ? -a_r : a_r) + tfu_pkg::ONE;
              cnt_nxt   = 6'd2;
              state_nxt = tfu_pkg::ST_EX_DIV;
            end
          end
          tfu_pkg::FN_LOG: begin
            if (a_r < 0) begin
              res_nxt = '0;
            end else if (a_r == '0) begin
              res_nxt = -tfu_pkg::ONE;
            end else begin
              cnt_nxt   = '0;
              state_nxt = tfu_pkg::ST_LG_SHIFT;
            end
          end
          default: begin
            if (a_r >= tfu_pkg::TWO) begin
              res_nxt = tfu_pkg::ONE;
            end else if (a_r <= -tfu_pkg::TWO) begin
              res_nxt = -tfu_pkg::ONE;
            end else begin
              state_nxt = tfu_pkg::ST_TH_X2;
            end
          end
        endcase
      end
      tfu_pkg::ST_SQ_INV: begin
        div_use = 1'b1;
        div_req.dividend = tfu_pkg::ONE;
        div_req.divisor  = a_r;
        if (div_ok) begin
          a_nxt     = q;
          state_nxt = tfu_pkg::ST_SQ_PREP;
        end
      end
      tfu_pkg::ST_SQ_PREP: begin
        l_nxt = (a_r >>> 1) + 32'sd1;
        if (a_r > tfu_pkg::ONE) begin
          u_nxt     = a_r;
          cnt_nxt   = '0;
          state_nxt = tfu_pkg::ST_SQ_CNT;
        end else begin
          cnt_nxt   = 6'(tfu_pkg::SQRT_DEF_ITER);
          state_nxt = tfu_pkg::ST_SQ_ITER;
        end
      end
      tfu_pkg::ST_SQ_CNT: begin
        // Count base-4 digits of the operand to set the Newton step count.
        if (u_r > 0) begin
          u_nxt   = u_r >>> 2;
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          state_nxt = tfu_pkg::ST_SQ_ITER;
        end
      end
      tfu_pkg::ST_SQ_ITER: begin
        if (cnt_r == '0) begin
          state_nxt = tfu_pkg::ST_SQ_FIN;
        end else begin
          div_use = 1'b1;
          div_req.dividend = a_r;
          div_req.divisor  = l_r;
          if (div_ok) begin
            sum_w   = l_r + q;
            l_nxt   = sum_w >>> 1;
            cnt_nxt = cnt_r - 6'd1;
          end
        end
      end
      tfu_pkg::ST_SQ_FIN: begin
        if (!inv_r) begin
          res_nxt   = l_r;
          state_nxt = tfu_pkg::ST_DONE;
        end else begin
          div_use = 1'b1;
          div_req.dividend = tfu_pkg::ONE;
          div_req.divisor  = l_r;
          if (div_ok) begin
            res_nxt   = q;
            state_nxt = tfu_pkg::ST_DONE;
          end
        end
      end
      tfu_pkg::ST_EX_DIV: begin
        div_use = 1'b1;
        div_req.dividend = a_r;
        div_req.divisor  = tfu_pkg::fx(cnt_r);
        if (div_ok) begin
          u_nxt     = q;
          state_nxt = tfu_pkg::ST_EX_MUL;
        end
      end
      tfu_pkg::ST_EX_MUL: begin
        mul_a = t_r;
        mul_b = u_r;
        t_nxt = mul_p;
        l_nxt = l_r + mul_p;
        // Stop after a term below the threshold or after the last term.
        if (mul_p < tfu_pkg::EXP_STOP || cnt_r == 6'(tfu_pkg::EXP_TERMS - 1)) begin
          state_nxt = tfu_pkg::ST_EX_FIN;
        end else begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = tfu_pkg::ST_EX_DIV;
        end
      end
      tfu_pkg::ST_EX_FIN: begin
        if (!inv_r) begin
          res_nxt   = l_r;
          state_nxt = tfu_pkg::ST_DONE;
        end else begin
          div_use = 1'b1;
          div_req.dividend = tfu_pkg::ONE;
          div_req.divisor  = l_r;
          if (div_ok) begin
            res_nxt   = q;
            state_nxt = tfu_pkg::ST_DONE;
          end
        end
      end
      tfu_pkg::ST_LG_SHIFT: begin
        // Halve the argument into (0, 2], counting the halvings.
        if (a_r > tfu_pkg::TWO && cnt_r < 6'(tfu_pkg::LOG_MAX_HALF)) begin
          a_nxt   = a_r >>> 1;
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          f_nxt     = a_r - tfu_pkg::ONE;
          state_nxt = tfu_pkg::ST_LG_DIV;
        end
      end
      tfu_pkg::ST_LG_DIV: begin
        div_use = 1'b1;
        div_req.dividend = f_r;
        div_req.divisor  = tfu_pkg::TWO + f_r;
        if (div_ok) begin
          s_nxt     = q;
          step_nxt  = '0;
          state_nxt = tfu_pkg::ST_LG_POLY;
        end
      end
      tfu_pkg::ST_LG_POLY: begin
        // Squares s and z, runs two Horner chains in w, then the final combination, one product a cycle.
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd0: begin mul_a = s_r; mul_b = s_r; z_nxt = mul_p; end
          4'd1: begin mul_a = z_r; mul_b = z_r; w_nxt = mul_p; end
          4'd2: begin mul_a = w_r; mul_b = tfu_pkg::LG5; t_nxt = mul_p; end
          4'd3: begin mul_a = w_r; mul_b = tfu_pkg::LG3 + t_r; t_nxt = mul_p; end
          4'd4: begin mul_a = w_r; mul_b = tfu_pkg::LG1 + t_r; t_nxt = mul_p; end
          4'd5: begin mul_a = w_r; mul_b = tfu_pkg::LG6; u_nxt = mul_p; end
          4'd6: begin mul_a = w_r; mul_b = tfu_pkg::LG4 + u_r; u_nxt = mul_p; end
          4'd7: begin mul_a = w_r; mul_b = tfu_pkg::LG2 + u_r; u_nxt = mul_p; end
          4'd8: begin mul_a = z_r; mul_b = tfu_pkg::LG0 + u_r; u_nxt = mul_p; end
          4'd9: begin mul_a = s_r; mul_b = f_r - (t_r + u_r); u_nxt = mul_p; end
          4'd10: begin
            mul_a = tfu_pkg::LN2_FIX;
            mul_b = tfu_pkg::fx(cnt_r);
            t_nxt = mul_p;
          end
          default: begin
            res_nxt   = t_r + f_r - u_r;
            state_nxt = tfu_pkg::ST_DONE;
          end
        endcase
      end
      tfu_pkg::ST_TH_X2: begin
        mul_a     = a_r;
        mul_b     = a_r;
        z_nxt     = mul_p;
        t_nxt     = mul_p;
        cnt_nxt   = 6'd4;
        state_nxt = tfu_pkg::ST_TH_LOOP;
      end
      tfu_pkg::ST_TH_LOOP: begin
        div_use = 1'b1;
        div_req.dividend = z_r;
        div_req.divisor  = tfu_pkg::fx({cnt_r[4:0], 1'b1}) + t_r;
        if (div_ok) begin
          t_nxt   = q;
          cnt_nxt = cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_nxt = tfu_pkg::ST_TH_FIN;
          end
        end
      end
      tfu_pkg::ST_TH_FIN: begin
        div_use = 1'b1;
        div_req.dividend = a_r;
        div_req.divisor  = tfu_pkg::ONE + t_r;
        if (div_ok) begin
          res_nxt   = q;
          state_nxt = tfu_pkg::ST_DONE;
        end
      end
      tfu_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 32'(res_r);
          state_nxt     = tfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tfu_pkg::ST_IDLE;
      end
    endcase

    // Issue a division once per use; hold pending until its done pulse.
    div_req.start = div_use && !div_pend_r;
    if (div_use && !div_pend_r) begin
      div_pend_nxt = 1'b1;
    end else if (div_ok) begin
      div_pend_nxt = 1'b0;
    end else begin
      div_pend_nxt = div_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tfu_pkg::ST_IDLE;
      div_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lim_r       <= tfu_pkg::EXP_LIM_RESET;
    end else begin
      state_r     <= state_nxt;
      div_pend_r  <= div_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        lim_r <= cfg_wdata;
      end
    end
    func_r     <= func_nxt;
    a_r        <= a_nxt;
    l_r        <= l_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    f_r        <= f_nxt;
    s_r        <= s_nxt;
    z_r        <= z_nxt;
    w_r        <= w_nxt;
    res_r      <= res_nxt;
    cnt_r      <= cnt_nxt;
    step_r     <= step_nxt;
    inv_r      <= inv_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == tfu_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // No division may be outstanding while a new operand can be taken.
  a_idle_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_pend_r) else $error("division pending while idle");

  // The divider answers only a request that the sequencer issued.
  a_div_done_req: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> div_pend_r) else $error("unrequested division result");

  // An accepted beat starts work, so the input closes the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("input open after accept");
`endif

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fixed_point_transcendental_unit
// Drives directed and random sqrt, exp, log and tanh beats through the stream
// ports under several idle patterns and saturation limits, predicts every
// result in Q16.16 and compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // One beat waiting to be sent: the function code and its operand.
  typedef struct {
    tfu_pkg::func_t fn;
    tfu_pkg::word_t op;
  } op_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] operand
  logic [1:0]  in_tuser;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] result
  logic        cfg_wen;
  logic [30:0] cfg_wdata;  // exp_saturation_limit

  op_beat_t       pending_ops[$];
  tfu_pkg::word_t results_due[$];
  tfu_pkg::func_t sent_fn;
  tfu_pkg::word_t sent_op;
  longint         sat_limit;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             fail_count;

  fixed_point_transcendental_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Q16.16 arithmetic. Every value is carried in a longint and wrapped back to
  // 32 bits after each sum, product or quotient, as the datapath does.
  // --------------------------------------------------------------------------
  function automatic longint wrap32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint qmul(longint a, longint b);
    return wrap32((a * b) >>> tfu_pkg::FRAC_BITS);
  endfunction

  // Shifted dividend over divisor, truncated toward zero; a zero divisor
  // saturates according to the sign of the dividend.
  function automatic longint qdiv(longint a, longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned q;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (ub == 0) return (a < 0) ? longint'(tfu_pkg::WMIN) : longint'(tfu_pkg::WMAX);
    q = (ua << tfu_pkg::FRAC_BITS) / ub;
    if ((a < 0) != (b < 0)) q = -q;
    return wrap32(longint'(q));
  endfunction

  function automatic longint q_int(longint n);
    return wrap32(n << tfu_pkg::FRAC_BITS);
  endfunction

  function automatic longint root_of(longint a);
    longint one;
    longint guess;
    longint s;
    int     steps;
    bit     flip;
    one = q_int(1);
    flip = 0;
    steps = tfu_pkg::FRAC_BITS;
    if (a < 0) return -1;
    if (a == 0 || a == one) return a;
    // Small fractions are handled through the root of their reciprocal.
    if (a < one && a > longint'(tfu_pkg::SQRT_SMALL)) begin
      flip = 1;
      a = qdiv(one, a);
    end
    if (a > one) begin
      steps = 0;
      for (s = a; s > 0; s = s >>> 2) steps++;
    end
    guess = wrap32((a >>> 1) + 1);
    for (int i = 0; i < steps; i++) guess = wrap32(guess + qdiv(a, guess)) >>> 1;
    return flip ? qdiv(one, guess) : guess;
  endfunction

  function automatic longint exp_of(longint v);
    longint one;
    longint total;
    longint term;
    bit     neg;
    one = q_int(1);
    if (v == 0) return one;
    if (v == one) return longint'(tfu_pkg::E_FIX);
    if (v >= sat_limit) return longint'(tfu_pkg::WMAX);
    if (v <= -sat_limit) return 0;
    neg = v < 0;
    if (neg) v = wrap32(-v);
    total = wrap32(v + one);
    term = v;
    // Taylor terms stop early once a term drops below the stop threshold.
    for (int i = 2; i < tfu_pkg::EXP_TERMS; i++) begin
      term = qmul(term, qdiv(v, q_int(i)));
      total = wrap32(total + term);
      if (term < longint'(tfu_pkg::EXP_STOP)) break;
    end
    return neg ? qdiv(one, total) : total;
  endfunction

  function automatic longint ln_of(longint x);
    longint one;
    longint two;
    longint xi;
    longint f;
    longint s;
    longint z;
    longint w;
    longint r;
    longint odd_part;
    longint even_part;
    int     k;
    one = q_int(1);
    two = q_int(2);
    if (x < 0) return 0;
    if (x == 0) return wrap32(-one);
    xi = x;
    k = 0;
    while (xi > two && k < tfu_pkg::WORD_BITS) begin
      xi = xi >>> 1;
      k++;
    end
    f = wrap32(xi - one);
    s = qdiv(f, wrap32(two + f));
    z = qmul(s, s);
    w = qmul(z, z);
    odd_part = qmul(w, wrap32(longint'(tfu_pkg::LG1) + qmul(w,
               wrap32(longint'(tfu_pkg::LG3) + qmul(w, longint'(tfu_pkg::LG5))))));
    even_part = qmul(z, wrap32(longint'(tfu_pkg::LG0) + qmul(w,
                wrap32(longint'(tfu_pkg::LG2) + qmul(w,
                wrap32(longint'(tfu_pkg::LG4) + qmul(w, longint'(tfu_pkg::LG6))))))));
    r = wrap32(odd_part + even_part);
    return wrap32(wrap32(qmul(longint'(tfu_pkg::LN2_FIX), q_int(k)) + f) -
                  qmul(s, wrap32(f - r)));
  endfunction

  function automatic longint tanh_of(longint x);
    longint x2;
    longint t;
    x2 = qmul(x, x);
    t = x2;
    if (x >= q_int(2)) return q_int(1);
    if (x <= -q_int(2)) return -q_int(1);
    // Continued fraction, evaluated from the innermost level outward.
    for (int i = 4; i > 0; i--) t = qdiv(x2, wrap32(q_int(2 * i + 1) + t));
    return qdiv(x, wrap32(q_int(1) + t));
  endfunction

  function automatic tfu_pkg::word_t transcendental_result(tfu_pkg::func_t fn,
                                                            tfu_pkg::word_t op);
    case (fn)
      tfu_pkg::FN_SQRT: return tfu_pkg::word_t'(root_of(longint'(op)));
      tfu_pkg::FN_EXP:  return tfu_pkg::word_t'(exp_of(longint'(op)));
      tfu_pkg::FN_LOG:  return tfu_pkg::word_t'(ln_of(longint'(op)));
      default:          return tfu_pkg::word_t'(tanh_of(longint'(op)));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock, and a hard stop in case the block hangs.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input driver. The prediction is made when a beat is accepted; the limit
  // copy only changes while nothing is in flight, so it always matches.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        results_due.push_back(transcendental_result(sent_fn, sent_op));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sent_fn   <= pending_ops[0].fn;
          sent_op   <= pending_ops[0].op;
          in_tdata  <= pending_ops[0].op;
          in_tuser  <= pending_ops[0].fn;
          in_tvalid <= 1'b1;
          void'(pending_ops.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: random back-pressure and an in-order compare of each beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          if (out_tdata !== results_due[0]) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, results_due[0],
                     out_tdata);
            fail_count++;
          end
          void'(results_due.pop_front());
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_op(tfu_pkg::func_t fn, tfu_pkg::word_t op);
    op_beat_t b;
    b.fn = fn;
    b.op = op;
    pending_ops.push_back(b);
  endtask

  // Operands are drawn from full-range words, a window around zero where the
  // series and iterations actually run, tiny fractions, and points close to
  // the thresholds of each function (one, two and the exp limit).
  function automatic tfu_pkg::word_t random_operand();
    int     off;
    longint base;
    off = int'($urandom_range(16)) - 8;
    case ($urandom_range(4))
      0: return tfu_pkg::word_t'($urandom);
      1: return tfu_pkg::word_t'(int'($urandom_range(2 * 262144)) - 262144);
      2: return tfu_pkg::word_t'(int'($urandom_range(128)) - 64);
      3: begin
        case ($urandom_range(3))
          0: base = q_int(1);
          1: base = q_int(2);
          2: base = sat_limit;
          default: base = 0;
        endcase
        if ($urandom_range(1)) base = -base;
        return tfu_pkg::word_t'(base + off);
      end
      default: return tfu_pkg::word_t'(int'($urandom_range(2 * 800000)) - 800000);
    endcase
  endfunction

  task automatic write_limit(logic [30:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    sat_limit = longint'(value);
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Waits until every beat has been sent and answered, then lets the longest
  // computation drain before anything else touches the block.
  task automatic drain();
    while (pending_ops.size() > 0 || in_tvalid || results_due.size() > 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence: a directed sweep of the special cases, then five random
  // phases, each with its own saturation limit; phases 0 and 4 share an idle pattern.
  // --------------------------------------------------------------------------
  initial begin
    logic [30:0] limits[5];
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cfg_wen        = 1'b0;
    cfg_wdata      = '0;
    sent_fn        = tfu_pkg::FN_SQRT;
    sent_op        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    sat_limit      = longint'(tfu_pkg::EXP_LIM_RESET);
    limits[0] = tfu_pkg::EXP_LIM_RESET;
    limits[1] = 31'd0;
    limits[2] = 31'h7FFFFFFF;
    limits[3] = 31'd196608;
    limits[4] = 31'($urandom_range(32'h000FFFFF));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Square root: negative, zero, one, the small-fraction boundary, extremes.
    queue_op(tfu_pkg::FN_SQRT, -1);
    queue_op(tfu_pkg::FN_SQRT, 0);
    queue_op(tfu_pkg::FN_SQRT, tfu_pkg::ONE);
    queue_op(tfu_pkg::FN_SQRT, tfu_pkg::SQRT_SMALL);
    queue_op(tfu_pkg::FN_SQRT, tfu_pkg::SQRT_SMALL + 1);
    queue_op(tfu_pkg::FN_SQRT, tfu_pkg::WMAX);
    queue_op(tfu_pkg::FN_SQRT, tfu_pkg::WMIN);
    // Exponential: zero, one, both saturation edges and the most negative word.
    queue_op(tfu_pkg::FN_EXP, 0);
    queue_op(tfu_pkg::FN_EXP, tfu_pkg::ONE);
    queue_op(tfu_pkg::FN_EXP, tfu_pkg::word_t'(sat_limit));
    queue_op(tfu_pkg::FN_EXP, tfu_pkg::word_t'(sat_limit - 1));
    queue_op(tfu_pkg::FN_EXP, tfu_pkg::word_t'(-sat_limit));
    queue_op(tfu_pkg::FN_EXP, tfu_pkg::word_t'(1 - sat_limit));
    queue_op(tfu_pkg::FN_EXP, tfu_pkg::WMIN);
    // Natural log: negative, zero, one, just above two, the largest word.
    queue_op(tfu_pkg::FN_LOG, -1);
    queue_op(tfu_pkg::FN_LOG, 0);
    queue_op(tfu_pkg::FN_LOG, tfu_pkg::ONE);
    queue_op(tfu_pkg::FN_LOG, tfu_pkg::TWO + 1);
    queue_op(tfu_pkg::FN_LOG, tfu_pkg::WMAX);
    // Tanh: both clamp edges, the points just inside them, zero, the most negative word.
    queue_op(tfu_pkg::FN_TANH, tfu_pkg::TWO);
    queue_op(tfu_pkg::FN_TANH, tfu_pkg::TWO - 1);
    queue_op(tfu_pkg::FN_TANH, -tfu_pkg::TWO);
    queue_op(tfu_pkg::FN_TANH, 1 - tfu_pkg::TWO);
    queue_op(tfu_pkg::FN_TANH, 0);
    queue_op(tfu_pkg::FN_TANH, tfu_pkg::WMIN);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      // Phase 0 keeps the reset limit; the others load a new one.
      if (ph > 0) write_limit(limits[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
        end
      endcase
      for (int n = 0; n < 126; n++) begin
        queue_op(tfu_pkg::func_t'($urandom_range(3)), random_operand());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tfu_pkg.sv
rtl/core/tfu_div.sv
rtl/core/fixed_point_transcendental_unit.sv
verif/testbench.sv
